>>> hw/rtl/gb3_pkg.sv
// ============================================================================
// gb3_pkg: shared definitions for the 3x3 Gaussian blur stream unit
// Field widths, register reset values, register indexes and the result word.
// ============================================================================
`default_nettype none

package gb3_pkg;

   // Default capacity of the line store in pixels.
   localparam int MAX_LINE_DEFAULT = 256;

   // Field widths.
   localparam int PIXEL_W      = 8;
   localparam int LINE_WIDTH_W = 9;
   localparam int COEFF_W      = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   // Smallest row width the filter handles.
   localparam int LINE_WIDTH_MIN = 3;

   // Register reset values.
   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET   = 9'd256;
   localparam logic [COEFF_W-1:0]      CORNER_COEFF_RESET = 16'd4922;
   localparam logic [COEFF_W-1:0]      EDGE_COEFF_RESET   = 16'd8113;
   localparam logic [COEFF_W-1:0]      CENTER_COEFF_RESET = 16'd13382;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_WIDTH   = 2'd0,
      CSR_CORNER_COEFF = 2'd1,
      CSR_EDGE_COEFF   = 2'd2,
      CSR_CENTER_COEFF = 2'd3
   } csr_index_type;

   // Datapath widths: a sum of four pixels, one weighted product, the accumulator.
   localparam int SUM_W     = PIXEL_W + 2;
   localparam int PROD_W    = SUM_W + COEFF_W;
   localparam int ACC_W     = PROD_W + 2;
   localparam int FRAC_BITS = 16;
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

   // Depth of the result queue; a power of two so the pointers wrap naturally.
   localparam int RSP_FIFO_DEPTH = 16;

   // One column of the 3x3 window.
   typedef struct packed {
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] mid;
      logic [PIXEL_W-1:0] bot;
   } column_type;

   // One result word as it waits in the result queue.
   typedef struct packed {
      logic [PIXEL_W-1:0] blurred;
      logic               end_of_row;
      logic               end_of_frame;
      logic               last_of_run;
   } rsp_word_type;

endpackage

`default_nettype wire

>>> hw/rtl/gb3_if.sv
// ============================================================================
// gb3_if: stream channels of the 3x3 Gaussian blur stream unit
// Pixel request channel and filtered result channel, valid/ready handshake.
// ============================================================================
`default_nettype none

interface gb3_req_if;
   logic                        valid;
   logic                        ready;
   logic [gb3_pkg::PIXEL_W-1:0] pixel_in;
   logic                        tail;

   modport source (output valid, output pixel_in, output tail, input ready);
   modport sink   (input valid, input pixel_in, input tail, output ready);
endinterface

interface gb3_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gb3_pkg::PIXEL_W-1:0] blurred;
   logic                        end_of_row;
   logic                        end_of_frame;
   logic                        last_of_run;

   modport source (output valid, output blurred, output end_of_row, output end_of_frame,
                   output last_of_run, input ready);
   modport sink   (input valid, input blurred, input end_of_row, input end_of_frame,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gaussian_blur_3x3_stream_unit.sv
// ============================================================================
// gaussian_blur_3x3_stream_unit: streaming 3x3 Gaussian blur, zero padded
// Raster pixels in, blurred pixels out, two line stores in one RAM.
// ============================================================================
// The unit takes one pixel word per clock and sustains that rate for as long
// as the result side keeps up; a result word passes the s1, s2 and s3
// registers into the output queue. The pipeline is set by the line store, a
// single RAM with one read and one write port and a registered read: the read
// is issued when the pixel is accepted and the updated pair of pixels is
// written back in the next clock. Consecutive pixels always sit in different
// columns, so a read never meets a pending write to the same entry. Output
// (x-1, y-1) is produced by pixel (x, y); the last pixel of a row produces two
// words, so the result queue absorbs the extra word and the output side
// drains it one word per clock while rsp.ready is high. req.ready drops only
// when the queue plus the words still in the pipeline could overflow it. A
// frame ends with one row of tail words, which brings out the last image row
// and returns the counters to the first row. The line store needs no clearing
// after reset: rows above the image are masked to zero, and configuration is
// to be changed only while idle, a rule the unit itself does not enforce.
// ============================================================================
`default_nettype none

module gaussian_blur_3x3_stream_unit #(
   parameter int MAX_LINE = gb3_pkg::MAX_LINE_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   gb3_req_if.sink                         req,
   gb3_rsp_if.source                       rsp,
   input  logic                            csr_write_enable,
   input  logic [gb3_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gb3_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int PIX_W   = gb3_pkg::PIXEL_W;
   localparam int COL_W   = $clog2(MAX_LINE);
   localparam int WID_W   = (COL_W + 1 > gb3_pkg::LINE_WIDTH_W) ? COL_W + 1
                                                                 : gb3_pkg::LINE_WIDTH_W;
   localparam int DEPTH   = gb3_pkg::RSP_FIFO_DEPTH;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int RES_W   = $clog2(DEPTH + 7);
   localparam int SUM_W   = gb3_pkg::SUM_W;
   localparam int PROD_W  = gb3_pkg::PROD_W;
   localparam int ACC_W   = gb3_pkg::ACC_W;
   localparam int LANES   = 2;
   localparam logic [1:0] ROW_SAT = 2'd2;

   // Configuration registers.
   logic [gb3_pkg::LINE_WIDTH_W-1:0] line_width_ff;
   logic [gb3_pkg::COEFF_W-1:0]      corner_coeff_ff;
   logic [gb3_pkg::COEFF_W-1:0]      edge_coeff_ff;
   logic [gb3_pkg::COEFF_W-1:0]      center_coeff_ff;

   // Raster position. The row count only needs to tell rows 0, 1 and 2-or-more apart.
   logic [COL_W-1:0] col_ff, col_in;
   logic [1:0]       row_ff, row_in;

   // Accept-side decode.
   logic              accept;
   logic [WID_W-1:0]  width_ext;
   logic [WID_W-1:0]  eff_width;
   logic              wrap;
   logic [1:0]        row_cur;
   logic [COL_W-1:0]  x;
   logic              at_last;
   logic              emit_first;
   logic              emit_second;
   logic [PIX_W-1:0]  pix_masked;

   // Line store: upper pixel in the high byte, middle pixel in the low byte.
   logic [2*PIX_W-1:0] line_mem [MAX_LINE];
   logic [2*PIX_W-1:0] line_rd_ff;

   // Stage 1: accepted pixel, line store data arrives alongside.
   logic              s1_valid_ff;
   logic [COL_W-1:0]  s1_x_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic              s1_tail_ff;
   logic              s1_col0_ff;
   logic              s1_ge1_ff;
   logic              s1_ge2_ff;
   logic              s1_first_ff;
   logic              s1_second_ff;

   // Window: older and newer column to the left of the incoming one.
   gb3_pkg::column_type win_old_ff, win_new_ff;
   gb3_pkg::column_type win_l, win_c, cur;
   gb3_pkg::column_type lane_l [LANES];
   gb3_pkg::column_type lane_c [LANES];
   gb3_pkg::column_type lane_r [LANES];

   // Stage 2: neighbourhood sums per lane.
   logic             s2_valid_ff;
   logic             s2_tail_ff;
   logic             s2_first_ff;
   logic             s2_second_ff;
   logic [SUM_W-1:0] s2_corners_ff [LANES];
   logic [SUM_W-1:0] s2_edges_ff   [LANES];
   logic [PIX_W-1:0] s2_center_ff  [LANES];

   // Stage 3: weighted products per lane.
   logic              s3_valid_ff;
   logic              s3_tail_ff;
   logic              s3_first_ff;
   logic              s3_second_ff;
   logic [PROD_W-1:0] s3_corner_prod_ff [LANES];
   logic [PROD_W-1:0] s3_edge_prod_ff   [LANES];
   logic [PROD_W-1:0] s3_center_prod_ff [LANES];

   logic [PIX_W-1:0]  lane_blurred [LANES];

   // Result queue.
   gb3_pkg::rsp_word_type fifo_mem [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  push_first, push_second, pop;
   gb3_pkg::rsp_word_type word_first, word_second;
   logic [PTR_W-1:0]      second_addr;
   logic [RES_W-1:0]      reserved;

   function automatic logic [1:0] row_step(input logic [1:0] r);
      return (r == ROW_SAT) ? ROW_SAT : r + 2'd1;
   endfunction

   function automatic logic [1:0] run_count(input logic a, input logic b);
      return {1'b0, a} + {1'b0, b};
   endfunction

   // ------------------------------------------------------------------------
   // Configuration port.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= gb3_pkg::LINE_WIDTH_RESET;
         corner_coeff_ff <= gb3_pkg::CORNER_COEFF_RESET;
         edge_coeff_ff   <= gb3_pkg::EDGE_COEFF_RESET;
         center_coeff_ff <= gb3_pkg::CENTER_COEFF_RESET;
      end else if (csr_write_enable) begin
         case (gb3_pkg::csr_index_type'(csr_index))
            gb3_pkg::CSR_LINE_WIDTH: begin
               line_width_ff <= csr_write_data[gb3_pkg::LINE_WIDTH_W-1:0];
            end
            gb3_pkg::CSR_CORNER_COEFF: begin
               corner_coeff_ff <= csr_write_data;
            end
            gb3_pkg::CSR_EDGE_COEFF: begin
               edge_coeff_ff <= csr_write_data;
            end
            gb3_pkg::CSR_CENTER_COEFF: begin
               center_coeff_ff <= csr_write_data;
            end
            default: begin
               line_width_ff <= line_width_ff;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Raster position and emission decode for the word being accepted.
   // ------------------------------------------------------------------------
   assign accept = req.valid && req.ready;

   always_comb begin
      width_ext = WID_W'(line_width_ff);
      if (width_ext < WID_W'(gb3_pkg::LINE_WIDTH_MIN)) begin
         eff_width = WID_W'(gb3_pkg::LINE_WIDTH_MIN);
      end else if (width_ext > WID_W'(MAX_LINE)) begin
         eff_width = WID_W'(MAX_LINE);
      end else begin
         eff_width = width_ext;
      end

      // A column at or beyond the row width (after the width shrank) ends the row.
      wrap    = WID_W'(col_ff) >= eff_width;
      row_cur = wrap ? row_step(row_ff) : row_ff;
      x       = wrap ? '0 : col_ff;
      at_last = WID_W'(x) == eff_width - WID_W'(1);

      emit_first  = (row_cur != 2'd0) && (x != '0);
      emit_second = (row_cur != 2'd0) && at_last;
      pix_masked  = req.tail ? '0 : req.pixel_in;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (at_last) begin
            col_in = '0;
            // The tail word in the last column ends the frame.
            row_in = req.tail ? 2'd0 : row_step(row_cur);
         end else begin
            col_in = COL_W'(x + COL_W'(1));
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------------
   // Line store: read at acceptance, write back the shifted pair in the next clock.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         line_rd_ff <= line_mem[x];
      end
      if (s1_valid_ff) begin
         line_mem[s1_x_ff] <= {line_rd_ff[PIX_W-1:0], s1_pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_x_ff      <= x;
         s1_pix_ff    <= pix_masked;
         s1_tail_ff   <= req.tail;
         s1_col0_ff   <= (x == '0);
         s1_ge1_ff    <= (row_cur != 2'd0);
         s1_ge2_ff    <= row_cur[1];
         s1_first_ff  <= emit_first;
         s1_second_ff <= emit_second;
      end
   end

   // ------------------------------------------------------------------------
   // Window and neighbourhood sums. Lane 0 is the result left of the new
   // column; lane 1 is the row-end result, with zero padding on its right.
   // ------------------------------------------------------------------------
   always_comb begin
      win_l = s1_col0_ff ? '0 : win_old_ff;
      win_c = s1_col0_ff ? '0 : win_new_ff;

      cur.top = s1_ge2_ff ? line_rd_ff[2*PIX_W-1:PIX_W] : '0;
      cur.mid = s1_ge1_ff ? line_rd_ff[PIX_W-1:0] : '0;
      cur.bot = s1_pix_ff;

      lane_l[0] = win_l;
      lane_c[0] = win_c;
      lane_r[0] = cur;
      lane_l[1] = win_c;
      lane_c[1] = cur;
      lane_r[1] = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_old_ff <= '0;
         win_new_ff <= '0;
      end else if (s1_valid_ff) begin
         win_old_ff <= win_c;
         win_new_ff <= cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         s2_tail_ff   <= s1_tail_ff;
         s2_first_ff  <= s1_first_ff;
         s2_second_ff <= s1_second_ff;
         for (int i = 0; i < LANES; i++) begin
            s2_corners_ff[i] <= SUM_W'(lane_l[i].top) + SUM_W'(lane_l[i].bot)
                              + SUM_W'(lane_r[i].top) + SUM_W'(lane_r[i].bot);
            s2_edges_ff[i]   <= SUM_W'(lane_c[i].top) + SUM_W'(lane_c[i].bot)
                              + SUM_W'(lane_l[i].mid) + SUM_W'(lane_r[i].mid);
            s2_center_ff[i]  <= lane_c[i].mid;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Weighting: three products per lane.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s2_valid_ff) begin
         s3_tail_ff   <= s2_tail_ff;
         s3_first_ff  <= s2_first_ff;
         s3_second_ff <= s2_second_ff;
         for (int i = 0; i < LANES; i++) begin
            s3_corner_prod_ff[i] <= PROD_W'(s2_corners_ff[i]) * PROD_W'(corner_coeff_ff);
            s3_edge_prod_ff[i]   <= PROD_W'(s2_edges_ff[i]) * PROD_W'(edge_coeff_ff);
            s3_center_prod_ff[i] <= PROD_W'(s2_center_ff[i]) * PROD_W'(center_coeff_ff);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Accumulate, round half up, drop the fraction and saturate to 255.
   // ------------------------------------------------------------------------
   always_comb begin
      logic [ACC_W-1:0]                      acc;
      logic [ACC_W-gb3_pkg::FRAC_BITS-1:0]   whole;
      for (int i = 0; i < LANES; i++) begin
         acc   = ACC_W'(s3_corner_prod_ff[i]) + ACC_W'(s3_edge_prod_ff[i])
               + ACC_W'(s3_center_prod_ff[i]) + gb3_pkg::ROUND_HALF;
         whole = acc[ACC_W-1:gb3_pkg::FRAC_BITS];
         lane_blurred[i] = (|whole[ACC_W-gb3_pkg::FRAC_BITS-1:PIX_W]) ? '1
                                                                     : whole[PIX_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Result queue: up to two words in, one word out per clock while ready.
   // ------------------------------------------------------------------------
   always_comb begin
      push_first  = s3_valid_ff && s3_first_ff;
      push_second = s3_valid_ff && s3_second_ff;
      pop         = rsp.valid && rsp.ready;

      word_first.blurred      = lane_blurred[0];
      word_first.end_of_row   = 1'b0;
      word_first.end_of_frame = 1'b0;
      word_first.last_of_run  = !s3_second_ff;

      word_second.blurred      = lane_blurred[1];
      word_second.end_of_row   = 1'b1;
      word_second.end_of_frame = s3_tail_ff;
      word_second.last_of_run  = 1'b1;

      second_addr = push_first ? PTR_W'(wr_ptr_ff + PTR_W'(1)) : wr_ptr_ff;

      wr_ptr_in = PTR_W'(wr_ptr_ff + PTR_W'(run_count(push_first, push_second)));
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + PTR_W'(1)) : rd_ptr_ff;
      count_in  = CNT_W'(count_ff + CNT_W'(run_count(push_first, push_second))
                         - CNT_W'(pop));

      // Room for every word still in the pipeline plus two for a new pixel.
      reserved = RES_W'(count_ff)
               + RES_W'(run_count(s1_valid_ff && s1_first_ff, s1_valid_ff && s1_second_ff))
               + RES_W'(run_count(s2_valid_ff && s2_first_ff, s2_valid_ff && s2_second_ff))
               + RES_W'(run_count(push_first, push_second));
   end

   always_ff @(posedge clock) begin
      if (push_first) begin
         fifo_mem[wr_ptr_ff] <= word_first;
      end
      if (push_second) begin
         fifo_mem[second_addr] <= word_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign req.ready        = reserved <= RES_W'(DEPTH - 2);
   assign rsp.valid        = count_ff != '0;
   assign rsp.blurred      = fifo_mem[rd_ptr_ff].blurred;
   assign rsp.end_of_row   = fifo_mem[rd_ptr_ff].end_of_row;
   assign rsp.end_of_frame = fifo_mem[rd_ptr_ff].end_of_frame;
   assign rsp.last_of_run  = fifo_mem[rd_ptr_ff].last_of_run;

endmodule

`default_nettype wire

>>> hw/rtl/gb3_checker.sv
// ============================================================================
// gb3_checker: port-level checks for the 3x3 Gaussian blur stream unit
// Watches the result channel and is bound to the top level.
// ============================================================================
`default_nettype none

module gb3_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_end_of_row,
   input logic rsp_end_of_frame,
   input logic rsp_last_of_run
);

   // A word offered and not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word withdrawn before it was taken");

   // The frame ends in the last column of the last row.
   a_eof_at_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> rsp_end_of_row)
      else $error("end of frame outside the last column");

   // The last column is always the final word caused by its pixel.
   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_row |-> rsp_last_of_run)
      else $error("end of row word not marked last of run");

   // Reset empties the result queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word offered right after reset");

endmodule

bind gaussian_blur_3x3_stream_unit gb3_checker u_gb3_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_end_of_row   (rsp.end_of_row),
   .rsp_end_of_frame (rsp.end_of_frame),
   .rsp_last_of_run  (rsp.last_of_run)
);

`default_nettype wire

>>> sim/gb3_blur_checker.sv
// ============================================================================
// gb3_blur_checker: result prediction and comparison for the blur unit
// Watches the pixel, result and register ports, keeps its own line stores,
// window and counters, and checks every result word against its prediction.
// ============================================================================
module gb3_blur_checker
   import gb3_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   gb3_req_if                     req,
   gb3_rsp_if                     rsp,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     fail_count,
   output int                     pending_words,
   output int                     checked_words
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROW_COUNT_MAX = 4095;
   localparam int PRINT_LIMIT   = 40;

   logic [LINE_WIDTH_W-1:0] width_reg;
   logic [COEFF_W-1:0]      corner_weight;
   logic [COEFF_W-1:0]      edge_weight;
   logic [COEFF_W-1:0]      center_weight;

   logic [PIXEL_W-1:0] older_row [MAX_LINE];
   logic [PIXEL_W-1:0] newer_row [MAX_LINE];
   column_type         win_left;
   column_type         win_mid;
   int                 col_pos;
   int                 row_pos;

   rsp_word_type blurred_due [$];
   int           mismatches;
   int           checked;

   task automatic report(input string msg);
      if (mismatches < PRINT_LIMIT) begin
         $display("%0t ns: %s", $time, msg);
      end
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report($sformatf("result word %0d, %s is %0d, expected %0d",
                          checked, name, got, want));
      end
   endtask

   function automatic logic [PIXEL_W-1:0] blur_value(column_type l, column_type c,
                                                     column_type r);
      longint unsigned corners;
      longint unsigned sides;
      longint unsigned acc;
      corners = 64'(l.top) + l.bot + r.top + r.bot;
      sides   = 64'(c.top) + c.bot + l.mid + r.mid;
      acc = corners * corner_weight + sides * edge_weight + 64'(c.mid) * center_weight;
      acc = (acc + 64'd32768) >> FRAC_BITS;
      return (acc > 255) ? 8'd255 : acc[PIXEL_W-1:0];
   endfunction

   // One accepted pixel word: advance the window and queue the words it causes.
   task automatic predict_blur(input logic [PIXEL_W-1:0] pixel, input logic is_tail);
      int                 w;
      int                 x;
      logic [PIXEL_W-1:0] pix;
      column_type         cur;
      rsp_word_type       first;
      rsp_word_type       second;
      bit                 have_first;
      bit                 have_second;

      w = int'(width_reg);
      if (w < LINE_WIDTH_MIN) w = LINE_WIDTH_MIN;
      if (w > MAX_LINE) w = MAX_LINE;
      pix = is_tail ? '0 : pixel;
      have_first = 1'b0;
      have_second = 1'b0;

      // A width cut below the current column closes the row first.
      if (col_pos >= w) begin
         col_pos = 0;
         if (row_pos < ROW_COUNT_MAX) row_pos++;
      end
      x = (col_pos >= MAX_LINE) ? MAX_LINE - 1 : col_pos;
      if (x == 0) begin
         win_left = '0;
         win_mid = '0;
      end

      cur.top = (row_pos >= 2) ? older_row[x] : '0;
      cur.mid = (row_pos >= 1) ? newer_row[x] : '0;
      cur.bot = pix;
      older_row[x] = newer_row[x];
      newer_row[x] = pix;

      if (row_pos >= 1 && x >= 1) begin
         first.blurred = blur_value(win_left, win_mid, cur);
         first.end_of_row = (x - 1 == w - 1);
         first.end_of_frame = 1'b0;
         first.last_of_run = 1'b0;
         have_first = 1'b1;
      end
      win_left = win_mid;
      win_mid = cur;

      // The last column also flushes itself against the zero padding.
      if (row_pos >= 1 && x == w - 1) begin
         second.blurred = blur_value(win_left, win_mid, '0);
         second.end_of_row = 1'b1;
         second.end_of_frame = is_tail;
         second.last_of_run = 1'b1;
         have_second = 1'b1;
      end else begin
         first.last_of_run = 1'b1;
      end
      if (have_first) blurred_due.push_back(first);
      if (have_second) blurred_due.push_back(second);

      if (x == w - 1) begin
         if (is_tail) begin
            col_pos = 0;
            row_pos = 0;
         end else begin
            col_pos = 0;
            if (row_pos < ROW_COUNT_MAX) row_pos++;
         end
      end else begin
         col_pos = x + 1;
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         width_reg = LINE_WIDTH_RESET;
         corner_weight = CORNER_COEFF_RESET;
         edge_weight = EDGE_COEFF_RESET;
         center_weight = CENTER_COEFF_RESET;
         win_left = '0;
         win_mid = '0;
         col_pos = 0;
         row_pos = 0;
         blurred_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_LINE_WIDTH:   width_reg = csr_write_data[LINE_WIDTH_W-1:0];
               CSR_CORNER_COEFF: corner_weight = csr_write_data[COEFF_W-1:0];
               CSR_EDGE_COEFF:   edge_weight = csr_write_data[COEFF_W-1:0];
               CSR_CENTER_COEFF: center_weight = csr_write_data[COEFF_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) predict_blur(req.pixel_in, req.tail);
         if (rsp.valid && rsp.ready) begin
            if (blurred_due.size() == 0) begin
               report($sformatf("result word with nothing expected, blurred %0d",
                                rsp.blurred));
            end else begin
               want = blurred_due.pop_front();
               check_field("blurred", rsp.blurred, want.blurred);
               check_field("end_of_row", rsp.end_of_row, want.end_of_row);
               check_field("end_of_frame", rsp.end_of_frame, want.end_of_frame);
               check_field("last_of_run", rsp.last_of_run, want.last_of_run);
               checked++;
            end
         end
      end
      pending_words <= blurred_due.size();
      fail_count <= mismatches;
      checked_words <= checked;
   end

endmodule

>>> sim/tb.sv
// ============================================================================
// tb: stimulus and verdict for the 3x3 Gaussian blur stream unit
// Sends raster frames with drain rows through the unit under changing widths
// and weights, throttles both stream sides, and reports the checker's result.
// ============================================================================
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gb3_pkg::*;

   // Pixel words in the whole run, the full-width frame and directed part included.
   localparam int TOTAL_WORDS = 850;
   localparam int WIDE = MAX_LINE_DEFAULT;
   // Settling covers pixels that produce nothing but are still in flight.
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RUN_LIMIT_NS = 3_000_000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   // Idle percentages of the sender and the receiver for the current phase.
   int   tx_idle_pct;
   int   rx_idle_pct;
   logic long_hold_go;
   logic rx_hold;

   int words_sent;
   int frames_sent;
   int fail_count;
   int pending_words;
   int checked_words;

   gb3_req_if req ();
   gb3_rsp_if rsp ();

   gaussian_blur_3x3_stream_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   gb3_blur_checker blur_check (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_words    (pending_words),
      .checked_words    (checked_words)
   );

   always #4 clock = ~clock;

   // Hard stop in case the unit hangs on either side.
   initial begin
      #RUN_LIMIT_NS;
      $display("TEST FAILED");
      $finish;
   end

   // Receiver: random back pressure, plus one long hold so that the result
   // queue fills up and the unit has to stall its pixel input.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // The long hold is counted here so the sender keeps offering words meanwhile.
   initial begin
      rx_hold = 1'b0;
      wait (long_hold_go);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      rx_hold <= 1'b0;
   end

   function automatic logic [PIXEL_W-1:0] random_pixel();
      int pick;
      pick = $urandom_range(19);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return PIXEL_W'($urandom_range(255));
   endfunction

   // Weights lean toward realistic kernel values but hit both extremes and
   // the power-on value now and then.
   function automatic int pick_weight(input logic [COEFF_W-1:0] reset_value);
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 0;
      if (pick == 1) return 65535;
      if (pick == 2) return int'(reset_value);
      if (pick <= 5) return $urandom_range(65535);
      return $urandom_range(20000);
   endfunction

   // Mostly narrow rows; register values below the minimum are clamped by the unit.
   function automatic int pick_width();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return $urandom_range(LINE_WIDTH_MIN - 1);
      if (pick == 1) return LINE_WIDTH_MIN;
      if (pick == 2) return $urandom_range(25, 40);
      return $urandom_range(4, 24);
   endfunction

   // Offer one pixel word after a random gap and hold it until it is taken.
   // Valid stays high when the next word follows without a gap.
   task automatic send_word(input logic [PIXEL_W-1:0] pixel, input logic is_tail);
      while ($urandom_range(99) < tx_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.pixel_in <= pixel;
      req.tail <= is_tail;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      words_sent++;
   endtask

   // A frame of image rows followed by its drain row of tail words. With noise
   // on, a rare tail word lands inside the image and an extra drain row may
   // follow the frame while the counters already sit on the first row.
   task automatic send_frame(input int width, input int height, input bit noisy);
      int x;
      int y;
      for (y = 0; y < height; y++) begin
         for (x = 0; x < width; x++) begin
            send_word(random_pixel(), noisy && ($urandom_range(199) == 0));
         end
      end
      for (x = 0; x < width; x++) send_word(random_pixel(), 1'b1);
      frames_sent++;
      if (noisy && $urandom_range(9) == 0) begin
         for (x = 0; x < width; x++) send_word(random_pixel(), 1'b1);
      end
   endtask

   // Stop offering words and wait until every predicted word has come out,
   // then give the pipeline time to empty of words that produce nothing.
   task automatic settle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input csr_index_type idx, input int value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   // Registers are only written while the unit is idle.
   task automatic write_config(input int width_value, input int corner_value,
                               input int edge_value, input int center_value);
      put_reg(CSR_LINE_WIDTH, width_value);
      put_reg(CSR_CORNER_COEFF, corner_value);
      put_reg(CSR_EDGE_COEFF, edge_value);
      put_reg(CSR_CENTER_COEFF, center_value);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int start_count;
      int random_budget;
      int progress;
      int phase;
      int width_value;
      int frame_width;
      int height;
      int frames;

      reset = 1'b1;
      req.valid = 1'b0;
      req.pixel_in = '0;
      req.tail = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_LINE_WIDTH;
      csr_write_data = '0;
      long_hold_go = 1'b0;
      tx_idle_pct = 37;
      rx_idle_pct = 77;
      words_sent = 0;
      frames_sent = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Power-on settings untouched: one full-width row and its drain row
      // check the reset width and the reset weights.
      send_frame(WIDE, 1, 1'b0);
      settle();

      // Directed: width register zero is clamped to three columns and all
      // weights at full scale, so nearly every word saturates. The image has
      // extreme pixels and a tail word inside the second row, whose pixel value
      // must be ignored. A drain row on the first row follows; it produces no
      // words and must leave the counters at the start of a frame.
      write_config(0, 65535, 65535, 65535);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h01, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'hFF, 1'b1);
      send_word(8'h7F, 1'b0);
      send_word(8'hAA, 1'b1);
      send_word(8'h55, 1'b1);
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b1);
      settle();

      // Directed: center weight one half and the rest zero, so odd pixels
      // land exactly between two codes and must round up.
      write_config(5, 0, 0, 16'h8000);
      send_word(8'h01, 1'b0);
      send_word(8'h03, 1'b0);
      send_word(8'hFE, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h02, 1'b0);
      send_word(8'h10, 1'b0);
      send_word(8'h20, 1'b0);
      send_word(8'h40, 1'b0);
      send_word(8'h08, 1'b0);
      settle();

      // The width shrinks while the second row stands at column four, beyond
      // the new width, so that row is taken as ended. The drain row then
      // follows on the narrower raster.
      write_config(2, 0, 0, 16'h8000);
      send_word(8'hC3, 1'b1);
      send_word(8'h3C, 1'b1);
      send_word(8'h81, 1'b1);
      settle();

      // Random part fills the rest of the word budget. The first third
      // throttles the receiver harder, the second third the sender, the last
      // third runs at full rate. Every phase ends with the sender paused until
      // all words are back.
      start_count = words_sent;
      random_budget = TOTAL_WORDS - start_count;
      phase = 0;
      while (words_sent < TOTAL_WORDS) begin
         progress = words_sent - start_count;
         if (progress < random_budget / 3) begin
            tx_idle_pct = 37;
            rx_idle_pct = 77;
         end else if (progress < 2 * random_budget / 3) begin
            tx_idle_pct = 77;
            rx_idle_pct = 37;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end

         width_value = pick_width();
         frames = $urandom_range(1, 3);
         height = 0;
         if (phase == 1) begin
            // A tall frame while the receiver holds off for a long stretch.
            width_value = 12;
            frames = 1;
            height = 6;
            long_hold_go <= 1'b1;
         end
         frame_width = (width_value < LINE_WIDTH_MIN) ? LINE_WIDTH_MIN :
                       (width_value > WIDE) ? WIDE : width_value;

         write_config(width_value, pick_weight(CORNER_COEFF_RESET),
                      pick_weight(EDGE_COEFF_RESET), pick_weight(CENTER_COEFF_RESET));
         repeat (frames) begin
            send_frame(frame_width, (height != 0) ? height : $urandom_range(1, 5), 1'b1);
         end
         settle();
         phase++;
      end

      $display("Run covered %0d frames in %0d phases: %0d pixel words in, %0d blurred words",
               frames_sent, phase, words_sent, checked_words);
      $display("checked across widths 3 to 256, clamped widths, extreme weights and stalls.");
      if (fail_count == 0 && pending_words == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
